// ----- hdl/assert_macros.svh -----
// Assertion macros used by the top level of the floppy controller command step.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clk edge outside reset.
`define FDC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clk edge outside reset.
`define FDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/fdc_pkg.sv -----
// Shared types and constants of the floppy controller command step.
package fdc_pkg;

  localparam int DRIVES = 2;
  localparam int CFG_DRIVES = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 13;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_D0_TRACKS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_D0_SPT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_D0_SIDES  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_D0_SECB   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_D1_TRACKS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_D1_SPT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_D1_SIDES  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_D1_SECB   = 3'd7;

  // Reset geometry
  localparam logic [7:0]  RST_TRACKS = 8'd80;
  localparam logic [5:0]  RST_SPT    = 6'd18;
  localparam logic [1:0]  RST_SIDES  = 2'd2;
  localparam logic [12:0] RST_SECB   = 13'd512;

  // Status bit positions
  localparam int ST_TRACK0 = 2;
  localparam int ST_ERROR  = 4;
  localparam int ST_SPIN   = 5;
  localparam int ST_MOTOR  = 7;

  // Command high nibble codes
  localparam logic [3:0] HI_READ_LAST  = 4'h9;
  localparam logic [3:0] HI_XFER_LAST  = 4'hB;
  localparam logic [3:0] HI_FORCE_INT  = 4'hD;

  // Limits of the transfer fields
  localparam logic [29:0] OFFSET_MAX = 30'h0FFF_FFFF;

  // Type I operations (command bits 6:4)
  typedef enum logic [2:0] {
    T1_RESTORE      = 3'd0,
    T1_SEEK         = 3'd1,
    T1_STEP         = 3'd2,
    T1_STEP_UPD     = 3'd3,
    T1_STEP_IN      = 3'd4,
    T1_STEP_IN_UPD  = 3'd5,
    T1_STEP_OUT     = 3'd6,
    T1_STEP_OUT_UPD = 3'd7
  } t1_op_t;

  typedef enum logic [1:0] {
    XFER_NONE  = 2'd0,
    XFER_READ  = 2'd1,
    XFER_WRITE = 2'd2
  } xfer_kind_t;

  localparam logic OP_LOAD_TRACK = 1'b0;

  typedef struct packed {
    logic        op;
    logic [7:0]  command;
    logic [7:0]  data_value;
    logic [7:0]  sector_number;
    logic [2:0]  select_bits;
    logic [7:0]  sector_count;
    logic [23:0] dma_address;
    logic        transfer_ok;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  status;
    logic [7:0]  track_value;
    logic [27:0] byte_offset;
    logic [19:0] transfer_bytes;
    logic [1:0]  transfer_kind;
    logic [23:0] dma_address_out;
    logic [7:0]  sector_count_out;
    logic        dma_done;
    logic        interrupt;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic mul3;
    logic commit;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic needs_mul;
  } dp_stat_t;

endpackage

// ----- hdl/floppy_controller_command_step.sv -----
// Top level of the floppy controller command step: sequencer, datapath, checks.
// Sequence: every accepted item passes S_MUL1 and S_FINISH; items that need the offset
//   (read/write commands on a valid drive) pass S_MUL1, S_MUL2, S_MUL3, S_FINISH for the
//   three-step datapath multiply chain (geometry product and byte count, linear sector, byte offset).
// S_FINISH waits out an output stall; the next item is taken while a result waits.
// Reset (rst, synchronous): geometry 80/18/2/512, heads and track 0, step inward.
`include "assert_macros.svh"

module floppy_controller_command_step (
  input  logic                           clk,
  input  logic                           rst,
  // command items
  input  logic                           in_valid,
  output logic                           in_stall,
  input  fdc_pkg::in_item_t              in_item,
  // result items
  output logic                           out_valid,
  input  logic                           out_stall,
  output fdc_pkg::out_item_t             out_item,
  // geometry configuration
  input  logic                           cfg_we,
  input  logic [fdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fdc_pkg::CFG_DATA_W-1:0] cfg_data
);

  fdc_pkg::dp_cmd_t  dp_cmd;
  fdc_pkg::dp_stat_t dp_stat;

  // Sequencer: owns both handshakes, steps the datapath once per state.
  fdc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_stat   (dp_stat),
    .dp_cmd    (dp_cmd)
  );

  // Datapath: geometry regs, head/track state, offset multiplies, result register.
  fdc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .dp_cmd    (dp_cmd),
    .dp_stat   (dp_stat),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_item  (out_item)
  );

  // One item in flight: accepting stalls the input until the result is stored.
  `FDC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input not stalled after accept")
  // A reported transfer direction always comes with the DMA done bit.
  `FDC_ASSERT_IMPLY(a_kind_has_done, out_valid && (out_item.transfer_kind != fdc_pkg::XFER_NONE), out_item.dma_done, "transfer kind without dma_done")
  // A DMA command that produced no transfer must flag an error.
  `FDC_ASSERT_IMPLY(a_failed_xfer_err, out_valid && out_item.dma_done && (out_item.transfer_kind == fdc_pkg::XFER_NONE), out_item.status[fdc_pkg::ST_ERROR], "failed transfer without error bit")
  // Track loads raise no interrupt and report a clear status.
  `FDC_ASSERT_IMPLY(a_load_quiet, out_valid && !out_item.interrupt, out_item.status == 8'd0, "track load with nonzero status")

endmodule

// ----- hdl/fdc_ctrl.sv -----
// Sequencer of the floppy controller command step: handshakes and datapath steps.
module fdc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  fdc_pkg::dp_stat_t dp_stat,
  output fdc_pkg::dp_cmd_t  dp_cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_FINISH
  } state_t;

  state_t state;
  logic   accept;
  logic   out_free;
  logic   commit;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign commit   = (state == S_FINISH) && out_free;

  always_comb begin
    dp_cmd        = '0;
    dp_cmd.load   = accept;
    dp_cmd.mul1   = (state == S_MUL1);
    dp_cmd.mul2   = (state == S_MUL2);
    dp_cmd.mul3   = (state == S_MUL3);
    dp_cmd.commit = commit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_stall  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !commit) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state    <= S_MUL1;
            in_stall <= 1'b1;
          end
        end
        S_MUL1: begin
          state <= dp_stat.needs_mul ? S_MUL2 : S_FINISH;
        end
        S_MUL2: state <= S_MUL3;
        S_MUL3: state <= S_FINISH;
        S_FINISH: begin
          if (commit) begin
            state     <= S_IDLE;
            in_stall  <= 1'b0;
            out_valid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/fdc_dp.sv -----
// Datapath of the floppy controller command step: geometry, head state, offset math.
module fdc_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  fdc_pkg::dp_cmd_t                    dp_cmd,
  output fdc_pkg::dp_stat_t                   dp_stat,
  input  fdc_pkg::in_item_t                   in_item,
  input  logic                                cfg_we,
  input  logic [fdc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fdc_pkg::CFG_DATA_W-1:0]      cfg_data,
  output fdc_pkg::out_item_t                  out_item
);

  // geometry registers
  logic [7:0]  cfg_tracks [fdc_pkg::CFG_DRIVES];
  logic [5:0]  cfg_spt    [fdc_pkg::CFG_DRIVES];
  logic [1:0]  cfg_sides  [fdc_pkg::CFG_DRIVES];
  logic [12:0] cfg_secb   [fdc_pkg::CFG_DRIVES];

  // controller state
  logic [7:0]  head_position [fdc_pkg::DRIVES];
  logic [7:0]  track_register;
  logic        step_dir;

  // item and product registers
  fdc_pkg::in_item_t itm;
  logic [7:0]  p_geo;
  logic [20:0] n_bytes;
  logic [12:0] sb_q;
  logic [5:0]  spt_q;
  logic [16:0] lin;
  logic [29:0] off;

  // decode
  logic [2:0]  nsel;
  logic        side;
  logic        drv_found;
  logic        drv_idx;
  logic        drive_ok;
  logic [3:0]  hi;
  logic [7:0]  sec_m1;
  logic [7:0]  head_cur;
  logic [7:0]  tracks_cur;

  assign nsel       = ~itm.select_bits;
  assign side       = nsel[0];
  assign drv_found  = (nsel[2:1] == 2'b01) || (nsel[2:1] == 2'b10);
  assign drv_idx    = nsel[2];
  assign drive_ok   = drv_found && (int'(drv_idx) < fdc_pkg::DRIVES);
  assign hi         = itm.command[7:4];
  assign sec_m1     = itm.sector_number - {7'd0, (itm.sector_number != 8'd0)};
  assign head_cur   = head_position[drv_idx];
  assign tracks_cur = cfg_tracks[drv_idx];

  assign dp_stat.needs_mul = (itm.op != fdc_pkg::OP_LOAD_TRACK) && drive_ok &&
                             itm.command[7] && (hi <= fdc_pkg::HI_XFER_LAST);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fdc_pkg::CFG_DRIVES; i++) begin
        cfg_tracks[i] <= fdc_pkg::RST_TRACKS;
        cfg_spt[i]    <= fdc_pkg::RST_SPT;
        cfg_sides[i]  <= fdc_pkg::RST_SIDES;
        cfg_secb[i]   <= fdc_pkg::RST_SECB;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        fdc_pkg::CFG_D0_TRACKS: cfg_tracks[0] <= cfg_data[7:0];
        fdc_pkg::CFG_D0_SPT:    cfg_spt[0]    <= cfg_data[5:0];
        fdc_pkg::CFG_D0_SIDES:  cfg_sides[0]  <= cfg_data[1:0];
        fdc_pkg::CFG_D0_SECB:   cfg_secb[0]   <= cfg_data[12:0];
        fdc_pkg::CFG_D1_TRACKS: cfg_tracks[1] <= cfg_data[7:0];
        fdc_pkg::CFG_D1_SPT:    cfg_spt[1]    <= cfg_data[5:0];
        fdc_pkg::CFG_D1_SIDES:  cfg_sides[1]  <= cfg_data[1:0];
        fdc_pkg::CFG_D1_SECB:   cfg_secb[1]   <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // offset pipeline: two multipliers in the first step, one in each of the others
  always_ff @(posedge clk) begin
    if (dp_cmd.load) itm <= in_item;
    if (dp_cmd.mul1) begin
      p_geo   <= 8'(cfg_spt[drv_idx] * cfg_sides[drv_idx]);
      n_bytes <= 21'(itm.sector_count * cfg_secb[drv_idx]);
      sb_q    <= cfg_secb[drv_idx];
      spt_q   <= cfg_spt[drv_idx];
    end
    if (dp_cmd.mul2) begin
      lin <= 17'(p_geo * head_cur) + (side ? {11'd0, spt_q} : 17'd0) + {9'd0, sec_m1};
    end
    if (dp_cmd.mul3) off <= 30'(lin * sb_q);
  end

  // Type I head motion
  logic [7:0]        step_in;
  logic [7:0]        step_out;
  logic signed [9:0] seek_sum;
  logic [7:0]        seek_head;
  logic [7:0]        head_next;
  logic [7:0]        track_next;
  logic              dir_next;
  logic              head_we;
  logic              xfer_valid;
  fdc_pkg::out_item_t res;

  assign step_in  = (head_cur < tracks_cur) ? head_cur + 8'd1 : head_cur;
  assign step_out = (head_cur != 8'd0) ? head_cur - 8'd1 : head_cur;
  assign seek_sum = $signed({2'b00, head_cur}) + $signed({2'b00, itm.data_value}) -
                    $signed({2'b00, track_register});
  assign seek_head = (seek_sum[9] || (seek_sum[8:0] >= {1'b0, tracks_cur})) ?
                     8'd0 : seek_sum[7:0];
  assign xfer_valid = (itm.sector_number != 8'd0) && (off <= fdc_pkg::OFFSET_MAX) &&
                      !n_bytes[20];

  always_comb begin
    head_next  = head_cur;
    track_next = track_register;
    dir_next   = step_dir;
    head_we    = 1'b0;
    res                  = '0;
    res.dma_address_out  = itm.dma_address;
    res.sector_count_out = itm.sector_count;
    res.interrupt        = 1'b1;
    res.transfer_kind    = fdc_pkg::XFER_NONE;

    if (itm.op == fdc_pkg::OP_LOAD_TRACK) begin
      track_next    = itm.data_value;
      res.interrupt = 1'b0;
    end else if (!itm.command[7]) begin
      if (drive_ok) begin
        head_we = 1'b1;
        unique case (fdc_pkg::t1_op_t'(itm.command[6:4]))
          fdc_pkg::T1_RESTORE: begin
            head_next  = 8'd0;
            track_next = 8'd0;
          end
          fdc_pkg::T1_SEEK: begin
            head_next  = seek_head;
            track_next = itm.data_value;
          end
          fdc_pkg::T1_STEP_UPD: begin
            head_next  = step_dir ? step_in : step_out;
            track_next = step_dir ? track_register + 8'd1 : track_register - 8'd1;
          end
          fdc_pkg::T1_STEP: head_next = step_dir ? step_in : step_out;
          fdc_pkg::T1_STEP_IN_UPD: begin
            head_next  = step_in;
            track_next = track_register + 8'd1;
            dir_next   = 1'b1;
          end
          fdc_pkg::T1_STEP_IN: begin
            head_next = step_in;
            dir_next  = 1'b1;
          end
          fdc_pkg::T1_STEP_OUT_UPD: begin
            head_next  = step_out;
            track_next = track_register - 8'd1;
            dir_next   = 1'b0;
          end
          fdc_pkg::T1_STEP_OUT: begin
            head_next = step_out;
            dir_next  = 1'b0;
          end
          default: ;
        endcase
        res.status[fdc_pkg::ST_TRACK0] = (head_next == 8'd0);
        res.status[fdc_pkg::ST_ERROR]  = (head_next != track_next) && itm.command[2];
        res.status[fdc_pkg::ST_SPIN]   = 1'b1;
      end else begin
        res.status[fdc_pkg::ST_ERROR] = 1'b1;
      end
    end else if (hi == fdc_pkg::HI_FORCE_INT) begin
      res.status = '0;
    end else if (drive_ok) begin
      if (hi <= fdc_pkg::HI_XFER_LAST) begin
        res.dma_done = 1'b1;
        if (!xfer_valid) begin
          res.status[fdc_pkg::ST_ERROR] = 1'b1;
        end else begin
          res.byte_offset    = off[27:0];
          res.transfer_bytes = n_bytes[19:0];
          res.transfer_kind  = (hi <= fdc_pkg::HI_READ_LAST) ? fdc_pkg::XFER_READ :
                                                               fdc_pkg::XFER_WRITE;
          if (itm.transfer_ok) begin
            res.dma_address_out  = itm.dma_address + {4'd0, n_bytes[19:0]};
            res.sector_count_out = 8'd0;
          end else begin
            res.status[fdc_pkg::ST_ERROR] = 1'b1;
          end
        end
      end else begin
        res.status[fdc_pkg::ST_ERROR] = 1'b1;
      end
      if (head_cur != track_register) res.status[fdc_pkg::ST_ERROR] = 1'b1;
    end else begin
      res.status[fdc_pkg::ST_ERROR] = 1'b1;
    end

    if (itm.op != fdc_pkg::OP_LOAD_TRACK) res.status[fdc_pkg::ST_MOTOR] = 1'b1;
    res.track_value = track_next;
  end

  // controller state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fdc_pkg::DRIVES; i++) head_position[i] <= 8'd0;
      track_register <= 8'd0;
      step_dir       <= 1'b1;
    end else if (dp_cmd.commit) begin
      track_register <= track_next;
      step_dir       <= dir_next;
      if (head_we) head_position[drv_idx] <= head_next;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.commit) out_item <= res;
  end

endmodule
